// File: hdl/acctilt_pkg.sv
// Shared constants, register indexes and the arctangent table for the tilt averager.
// No dependencies; every other file but acctilt_fifo imports this package.
package acctilt_pkg;

    localparam int CORDIC_STEPS = 48;
    localparam int PRESCALE     = 40;
    localparam int ANG_W        = 47;              // table entry width, 45 deg = 2^46
    localparam int DEV_W        = 18;              // signed deviation width
    localparam int MAG_W        = 17;              // deviation magnitude width
    localparam int CX_W         = 60;              // CORDIC x/y width
    localparam int Z_W          = 50;              // CORDIC angle accumulator width
    localparam int TOT_W        = 50;              // unsigned full-circle angle width
    localparam int DEG_W        = 9;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int SPR_W        = 7;
    localparam int SAMPLE_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPR  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFX = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFY = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFZ = 8'd3;

    localparam logic [SPR_W-1:0]           SPR_RESET  = 7'd10;
    localparam logic signed [SAMPLE_W-1:0] OFFX_RESET = 16'sd507;
    localparam logic signed [SAMPLE_W-1:0] OFFY_RESET = 16'sd520;
    localparam logic signed [SAMPLE_W-1:0] OFFZ_RESET = 16'sd500;

    localparam logic [63:0] PI_Q62 = 64'h3243F6A8885A308D;

    typedef logic [ANG_W-1:0] atan_tab_t [CORDIC_STEPS];

    // atan(2^-i) in units of 45/2^46 degree: series in Q62, then divide by pi/4
    function automatic atan_tab_t atan_table();
        atan_tab_t   tab;
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] dvs;
        logic [63:0] rad;
        logic [63:0] r;
        logic [63:0] q;
        int          sh;
        tab[0] = ANG_W'(64'd1 << 46);
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            rad = 64'd0;
            for (int k = 0; k < 32; k++) begin
                sh = i * (2 * k + 1);
                if (sh < 63) begin
                    num = (64'd1 << 62) >> sh;
                    dvs = 64'(2 * k + 1);
                    quo = 64'd0;
                    rem = 64'd0;
                    for (int b = 63; b >= 0; b--) begin
                        rem = {rem[62:0], num[b]};
                        if (rem >= dvs) begin
                            rem    = rem - dvs;
                            quo[b] = 1'b1;
                        end
                    end
                    if (k % 2 == 1) rad = rad - quo;
                    else rad = rad + quo;
                end
            end
            r = rad;
            q = 64'd0;
            for (int b = 0; b < 46; b++) begin
                r = r << 1;
                q = q << 1;
                if (r >= PI_Q62) begin
                    r    = r - PI_Q62;
                    q[0] = 1'b1;
                end
            end
            tab[i] = ANG_W'(q);
        end
        return tab;
    endfunction

endpackage

// File: hdl/acctilt_fifo.sv
// Two-entry queue between the sample accumulator and the angle engine.
// Depends on nothing.
module acctilt_fifo #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);
    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         do_push;
    logic         do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)      count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push) count_reg <= count_reg - 2'd1;
        end
    end
endmodule

// File: hdl/acctilt_front.sv
// Accumulator front end: sums samples per group and hands finished groups to the queue.
// Depends on acctilt_pkg.
module acctilt_front #(
    parameter int MAX_SAMPLES = 64,
    parameter int SW = 22,
    parameter int CW = 7
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [3*acctilt_pkg::SAMPLE_W-1:0] s_data,
    input  logic [acctilt_pkg::SPR_W-1:0]     samples_per_result,
    output logic                              push_valid,
    input  logic                              push_ready,
    output logic [3*SW+CW-1:0]                push_data
);
    import acctilt_pkg::*;

    localparam int NW = (CW > SPR_W) ? CW : SPR_W;

    logic signed [SW-1:0] sum_reg [3];
    logic signed [SW-1:0] sum_next [3];
    logic [CW-1:0]        taken_reg;
    logic [CW-1:0]        taken_inc;
    logic [NW-1:0]        n_eff;
    logic                 accept;
    logic                 group_done;

    always_comb begin
        if (samples_per_result == '0) n_eff = NW'(1);
        else if (NW'(samples_per_result) > NW'(MAX_SAMPLES)) n_eff = NW'(MAX_SAMPLES);
        else n_eff = NW'(samples_per_result);
        for (int a = 0; a < 3; a++) begin
            sum_next[a] = sum_reg[a]
                + SW'($signed(s_data[a*SAMPLE_W +: SAMPLE_W]));
        end
    end

    assign taken_inc  = taken_reg + CW'(1);
    assign accept     = s_valid && s_ready;
    assign group_done = (NW'(taken_inc) >= n_eff);
    assign s_ready    = push_ready;
    assign push_valid = accept && group_done;
    assign push_data  = {taken_inc, sum_next[2], sum_next[1], sum_next[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg <= '0;
            for (int a = 0; a < 3; a++) sum_reg[a] <= '0;
        end else if (accept) begin
            if (group_done) begin
                taken_reg <= '0;
                for (int a = 0; a < 3; a++) sum_reg[a] <= '0;
            end else begin
                taken_reg <= taken_inc;
                for (int a = 0; a < 3; a++) sum_reg[a] <= sum_next[a];
            end
        end
    end
endmodule

// File: hdl/acctilt_back.sv
// Angle engine: serial divider for averages, shared CORDIC, degree scaling, output register.
// Depends on acctilt_pkg.
module acctilt_back #(
    parameter int SW = 22,
    parameter int CW = 7
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  logic [3*SW+CW-1:0]                  pop_data,
    input  logic signed [acctilt_pkg::SAMPLE_W-1:0] offset_x,
    input  logic signed [acctilt_pkg::SAMPLE_W-1:0] offset_y,
    input  logic signed [acctilt_pkg::SAMPLE_W-1:0] offset_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [acctilt_pkg::DEG_W-1:0]       angle_yz,
    output logic [acctilt_pkg::DEG_W-1:0]       angle_xz,
    output logic [acctilt_pkg::DEG_W-1:0]       angle_xy
);
    import acctilt_pkg::*;

    localparam int BW = (SW > 1) ? $clog2(SW) : 1;
    localparam atan_tab_t ATAN_TAB = atan_table();
    localparam logic [TOT_W-1:0] U2 = TOT_W'(1) << 47;
    localparam logic [TOT_W-1:0] U4 = TOT_W'(1) << 48;
    localparam logic [TOT_W-1:0] U8 = TOT_W'(1) << 49;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_SETUP, S_CORD, S_TOT, S_SCALE, S_OUT
    } state_t;

    state_t                  state_reg;
    logic signed [SW-1:0]    sum_reg [1:2];
    logic [CW-1:0]           cnt_reg;
    logic [1:0]              axis_reg;
    logic [BW-1:0]           bit_reg;
    logic [CW:0]             rem_reg;
    logic [SW-1:0]           quo_reg;
    logic                    neg_reg;
    logic signed [DEV_W-1:0] nd_reg [3];
    logic [1:0]              pair_reg;
    logic signed [CX_W-1:0]  x_reg;
    logic signed [CX_W-1:0]  y_reg;
    logic signed [Z_W-1:0]   z_reg;
    logic [5:0]              iter_reg;
    logic                    xneg_reg;
    logic                    yneg_reg;
    logic [TOT_W-1:0]        tot_reg;
    logic [DEG_W-1:0]        ang_reg [3];
    logic                    m_valid_reg;
    logic [DEG_W-1:0]        out_reg [3];

    logic [CW:0]             trial;
    logic [CW:0]             rem_next;
    logic [SW-1:0]           quo_next;
    logic signed [DEV_W-1:0] avg;
    logic signed [DEV_W-1:0] off_sel;
    logic signed [DEV_W-1:0] nd_new;
    logic signed [SW-1:0]    sum_sel;
    logic signed [DEV_W-1:0] yy;
    logic signed [DEV_W-1:0] xx;
    logic [MAG_W-1:0]        mag_a;
    logic [MAG_W-1:0]        mag_b;
    logic signed [CX_W-1:0]  xs;
    logic signed [CX_W-1:0]  ys;
    logic signed [Z_W-1:0]   tab_z;
    logic [TOT_W-1:0]        phi;
    logic [TOT_W+5:0]        prod;

    assign pop_ready = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign angle_yz  = out_reg[0];
    assign angle_xz  = out_reg[1];
    assign angle_xy  = out_reg[2];

    always_comb begin
        // one restoring division step
        trial = {rem_reg[CW-1:0], quo_reg[SW-1]};
        if (trial >= (CW+1)'(cnt_reg)) begin
            rem_next = trial - (CW+1)'(cnt_reg);
            quo_next = {quo_reg[SW-2:0], 1'b1};
        end else begin
            rem_next = trial;
            quo_next = {quo_reg[SW-2:0], 1'b0};
        end
        avg = neg_reg ? -$signed(DEV_W'(quo_next)) : $signed(DEV_W'(quo_next));
        case (axis_reg)
            2'd0:    off_sel = DEV_W'(offset_x);
            2'd1:    off_sel = DEV_W'(offset_y);
            default: off_sel = DEV_W'(offset_z);
        endcase
        nd_new = off_sel - avg;
        case (axis_reg)
            2'd0:    sum_sel = sum_reg[1];
            default: sum_sel = sum_reg[2];
        endcase

        case (pair_reg)
            2'd0:    begin yy = nd_reg[1]; xx = nd_reg[2]; end
            2'd1:    begin yy = nd_reg[0]; xx = nd_reg[2]; end
            default: begin yy = nd_reg[1]; xx = nd_reg[0]; end
        endcase
        mag_a = MAG_W'(xx < 0 ? -xx : xx);
        mag_b = MAG_W'(yy < 0 ? -yy : yy);

        xs    = x_reg >>> iter_reg;
        ys    = y_reg >>> iter_reg;
        tab_z = $signed(Z_W'(ATAN_TAB[iter_reg]));

        if (z_reg < 0) phi = '0;
        else if (TOT_W'(z_reg) > U2) phi = U2;
        else phi = TOT_W'(z_reg);

        prod = ((TOT_W+6)'(tot_reg) << 5) + ((TOT_W+6)'(tot_reg) << 3)
             + ((TOT_W+6)'(tot_reg) << 2) + (TOT_W+6)'(tot_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == S_OUT && (!m_valid_reg || m_ready)) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (pop_valid) begin
                        sum_reg[1] <= pop_data[SW +: SW];
                        sum_reg[2] <= pop_data[2*SW +: SW];
                        cnt_reg    <= pop_data[3*SW +: CW];
                        quo_reg    <= SW'(pop_data[SW-1] ? -$signed(pop_data[0 +: SW])
                                                         : $signed(pop_data[0 +: SW]));
                        neg_reg    <= pop_data[SW-1];
                        rem_reg    <= '0;
                        bit_reg    <= '0;
                        axis_reg   <= 2'd0;
                        state_reg  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (bit_reg == BW'(SW - 1)) begin
                        nd_reg[axis_reg] <= nd_new;
                        rem_reg <= '0;
                        bit_reg <= '0;
                        quo_reg <= SW'(sum_sel < 0 ? -sum_sel : sum_sel);
                        neg_reg <= (sum_sel < 0);
                        if (axis_reg == 2'd2) begin
                            pair_reg  <= 2'd0;
                            state_reg <= S_SETUP;
                        end else begin
                            axis_reg <= axis_reg + 2'd1;
                        end
                    end else begin
                        rem_reg <= rem_next;
                        quo_reg <= quo_next;
                        bit_reg <= bit_reg + BW'(1);
                    end
                end
                S_SETUP: begin
                    x_reg    <= $signed({3'b000, mag_a, 40'b0});
                    y_reg    <= $signed({3'b000, mag_b, 40'b0});
                    xneg_reg <= (xx < 0);
                    yneg_reg <= (yy < 0);
                    iter_reg <= '0;
                    // on an axis or at the origin the angle is exact: skip the rotation
                    if (mag_b == '0) begin
                        z_reg     <= '0;
                        state_reg <= S_TOT;
                    end else if (mag_a == '0) begin
                        z_reg     <= $signed(Z_W'(U2));
                        state_reg <= S_TOT;
                    end else begin
                        z_reg     <= '0;
                        state_reg <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (y_reg >= 0) begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + tab_z;
                    end else begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - tab_z;
                    end
                    iter_reg <= iter_reg + 6'd1;
                    if (iter_reg == 6'(CORDIC_STEPS - 1)) state_reg <= S_TOT;
                end
                S_TOT: begin
                    if (xneg_reg) tot_reg <= yneg_reg ? phi : U8 - phi;
                    else          tot_reg <= yneg_reg ? U4 - phi : U4 + phi;
                    state_reg <= S_SCALE;
                end
                S_SCALE: begin
                    ang_reg[pair_reg] <= prod[54:46];
                    if (pair_reg == 2'd2) begin
                        state_reg <= S_OUT;
                    end else begin
                        pair_reg  <= pair_reg + 2'd1;
                        state_reg <= S_SETUP;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg   <= ang_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_reg[0] <= 9'd360 && out_reg[1] <= 9'd360 && out_reg[2] <= 9'd360))
        else $error("angle above 360");
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (cnt_reg != '0))
        else $error("divide by zero count");
    a_cord_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CORD && iter_reg == 6'(CORDIC_STEPS - 1)) |=> (state_reg == S_TOT))
        else $error("rotation did not finish");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && state_reg == S_IDLE) |=> (state_reg == S_DIV))
        else $error("group pop lost");
`endif
endmodule

// File: hdl/accel_tilt_angle_averager.sv
// Tilt-angle averager: sample input at 1 per cycle while the group queue has room; one
// result of three angles per group. Averages come from the shared one-bit-per-cycle
// divider and angles from the 48-step CORDIC. The two-entry group queue lets
// accumulation run on while angles are worked out. Reset (aresetn, synchronous, low)
// clears sums, count, queue and output valid, and loads the register defaults.
module accel_tilt_angle_averager #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // angle_yz[8:0], angle_xz[17:9], angle_xy[26:18], zeros
    input  logic        cfg_wr_en,
    input  logic [acctilt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [acctilt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import acctilt_pkg::*;

    // sum width grows with the group size; count must hold MAX_SAMPLES itself
    localparam int SW = SAMPLE_W + ((MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 0);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int QW = 3 * SW + CW;

    logic [SPR_W-1:0]           spr_reg;
    logic signed [SAMPLE_W-1:0] offx_reg;
    logic signed [SAMPLE_W-1:0] offy_reg;
    logic signed [SAMPLE_W-1:0] offz_reg;

    logic          push_valid;
    logic          push_ready;
    logic [QW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [QW-1:0] pop_data;
    logic [DEG_W-1:0] ang_yz;
    logic [DEG_W-1:0] ang_xz;
    logic [DEG_W-1:0] ang_xy;

    // configuration: write-only, unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spr_reg  <= SPR_RESET;
            offx_reg <= OFFX_RESET;
            offy_reg <= OFFY_RESET;
            offz_reg <= OFFZ_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SPR:  spr_reg  <= cfg_wdata[SPR_W-1:0];
                CFG_OFFX: offx_reg <= cfg_wdata;
                CFG_OFFY: offy_reg <= cfg_wdata;
                CFG_OFFZ: offz_reg <= cfg_wdata;
                default:  ;
            endcase
        end
    end

    // front: take one sample transaction per cycle while the queue has room, push finished group sums
    acctilt_front #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .SW(SW),
        .CW(CW)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_tvalid),
        .s_ready           (s_tready),
        .s_data            (s_tdata),
        .samples_per_result(spr_reg),
        .push_valid        (push_valid),
        .push_ready        (push_ready),
        .push_data         (push_data)
    );

    // hold up to two finished groups while the back end is busy
    acctilt_fifo #(
        .W(QW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    // back: average, offset, three angles, registered result
    acctilt_back #(
        .SW(SW),
        .CW(CW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_data (pop_data),
        .offset_x (offx_reg),
        .offset_y (offy_reg),
        .offset_z (offz_reg),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .angle_yz (ang_yz),
        .angle_xz (ang_xz),
        .angle_xy (ang_xy)
    );

    assign m_tdata = {5'b00000, ang_xy, ang_xz, ang_yz};
endmodule

// File: sim/tilt_checker.sv
// Scoreboard for the tilt averager: watches the sample, result and register ports,
// predicts each result and compares it. Depends on acctilt_pkg for the register indexes.
module tilt_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import acctilt_pkg::*;

    localparam longint ONE45 = 64'sd1 << 46;

    typedef struct packed {
        logic [8:0] yz;
        logic [8:0] xz;
        logic [8:0] xy;
    } angles_t;

    angles_t     angle_fifo[$];
    longint      atan_q[48];
    logic [6:0]  group_size;
    int          off_x, off_y, off_z;
    int          acc_x, acc_y, acc_z;
    int          taken;

    initial begin
        longint      rad;
        longint      term;
        logic [63:0] r;
        logic [63:0] q;
        atan_q[0] = ONE45;
        for (int i = 1; i < 48; i++) begin
            rad = 0;
            for (int k = 0; i * (2 * k + 1) < 63; k++) begin
                term = longint'((64'd1 << 62) >> (i * (2 * k + 1)));
                term = term / (2 * k + 1);
                rad  = (k % 2) ? rad - term : rad + term;
            end
            r = rad;
            q = 0;
            for (int b = 0; b < 46; b++) begin
                r = r << 1;
                q = q << 1;
                if (r >= 64'h3243F6A8885A308D) begin
                    r    = r - 64'h3243F6A8885A308D;
                    q[0] = 1'b1;
                end
            end
            atan_q[i] = longint'(q);
        end
    end

    // floor(degrees(atan2(yy, xx)) + 180), atan2(0,0) taken as 0
    function automatic logic [8:0] tilt_deg(longint yy, longint xx);
        longint a, b, phi, tot, cx, cy, cz, xs;
        logic [63:0] scaled;
        a = (xx < 0) ? -xx : xx;
        b = (yy < 0) ? -yy : yy;
        if (a == 0 && b == 0) return 9'd180;
        if (b == 0) phi = 0;
        else if (a == 0) phi = 2 * ONE45;
        else begin
            cx = a <<< 40;
            cy = b <<< 40;
            cz = 0;
            for (int i = 0; i < 48; i++) begin
                xs = cx >>> i;
                if (cy >= 0) begin
                    cx = cx + (cy >>> i);
                    cy = cy - xs;
                    cz = cz + atan_q[i];
                end else begin
                    cx = cx - (cy >>> i);
                    cy = cy + xs;
                    cz = cz - atan_q[i];
                end
            end
            phi = cz;
        end
        if (phi < 0) phi = 0;
        if (phi > 2 * ONE45) phi = 2 * ONE45;
        if (xx >= 0) tot = (yy >= 0) ? 4 * ONE45 + phi : 4 * ONE45 - phi;
        else tot = (yy >= 0) ? 8 * ONE45 - phi : phi;
        scaled = (64'(tot) * 64'd45) >> 46;
        return scaled[8:0];
    endfunction

    // accumulate one sample; queue the angles when the group closes
    task automatic accumulate(logic [47:0] smp);
        int     lim;
        longint dx, dy, dz;
        angles_t exp_a;
        lim = group_size;
        if (lim < 1) lim = 1;
        if (lim > 64) lim = 64;
        acc_x += int'($signed(smp[15:0]));
        acc_y += int'($signed(smp[31:16]));
        acc_z += int'($signed(smp[47:32]));
        taken++;
        if (taken >= lim) begin
            dx = longint'(acc_x / taken) - off_x;
            dy = longint'(acc_y / taken) - off_y;
            dz = longint'(acc_z / taken) - off_z;
            exp_a.yz = tilt_deg(-dy, -dz);
            exp_a.xz = tilt_deg(-dx, -dz);
            exp_a.xy = tilt_deg(-dy, -dx);
            angle_fifo.push_back(exp_a);
            acc_x = 0; acc_y = 0; acc_z = 0; taken = 0;
        end
    endtask

    assign pending = angle_fifo.size();

    initial errors = 0;

    always @(posedge aclk) begin
        angles_t got;
        angles_t want;
        if (!aresetn) begin
            group_size = 7'd10;
            off_x = 507; off_y = 520; off_z = 500;
            acc_x = 0; acc_y = 0; acc_z = 0; taken = 0;
            angle_fifo.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SPR:  group_size = cfg_wdata[6:0];
                    CFG_OFFX: off_x = int'($signed(cfg_wdata));
                    CFG_OFFY: off_y = int'($signed(cfg_wdata));
                    CFG_OFFZ: off_z = int'($signed(cfg_wdata));
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) accumulate(s_tdata);
            if (m_tvalid && m_tready) begin
                got.yz = m_tdata[8:0];
                got.xz = m_tdata[17:9];
                got.xy = m_tdata[26:18];
                if (angle_fifo.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %0d %0d %0d",
                             $time, got.yz, got.xz, got.xy);
                end else begin
                    want = angle_fifo.pop_front();
                    if (got.yz !== want.yz) begin
                        errors++;
                        $display("%0t: angle_yz expected %0d got %0d", $time, want.yz, got.yz);
                    end
                    if (got.xz !== want.xz) begin
                        errors++;
                        $display("%0t: angle_xz expected %0d got %0d", $time, want.xz, got.xz);
                    end
                    if (got.xy !== want.xy) begin
                        errors++;
                        $display("%0t: angle_xy expected %0d got %0d", $time, want.xy, got.xy);
                    end
                end
            end
        end
    end

endmodule

// File: sim/tb.sv
// Top of the tilt averager testbench: clock, reset, register writes, sample stimulus
// and result back-pressure. Depends on acctilt_pkg, the block and tilt_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import acctilt_pkg::*;

    // an index past the register list; the block must ignore it
    localparam logic [7:0] CFG_NONE = 8'd200;

    // traffic shaping modes per phase
    localparam int MODE_FREE   = 0;
    localparam int MODE_SRC    = 1;
    localparam int MODE_SINK   = 2;
    localparam int MODE_BOTH   = 3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    int errors;
    int pending;
    int mode = MODE_FREE;
    int holdoff_req = 0;
    int holdoff_done = 0;
    int cycles = 0;
    int ox = 507, oy = 520, oz = 500;

    always #1 aclk = ~aclk;

    accel_tilt_angle_averager uut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_wr_en, .cfg_index, .cfg_wdata
    );

    tilt_checker scoreboard (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_wr_en, .cfg_index, .cfg_wdata,
        .errors, .pending
    );

    // watchdog: the slowest legal run is well under this
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 4000000) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // result side: stall per mode, or hold off for a long stretch on request
    initial begin
        forever begin
            @(negedge aclk);
            if (holdoff_done != holdoff_req) begin
                m_tready <= 1'b0;
                repeat (1500) @(negedge aclk);
                holdoff_done++;
                m_tready <= 1'b1;
            end else if (mode == MODE_SINK) m_tready <= ($urandom_range(99) >= 63);
            else if (mode == MODE_BOTH) m_tready <= ($urandom_range(99) >= 20);
            else m_tready <= 1'b1;
        end
    end

    // one register write per cycle; caller drops the enable after a batch
    task automatic reg_write(logic [7:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic set_regs(logic [6:0] grp, int nx, int ny, int nz);
        reg_write(CFG_SPR, 16'(grp));
        reg_write(CFG_OFFX, 16'(nx));
        reg_write(CFG_OFFY, 16'(ny));
        reg_write(CFG_OFFZ, 16'(nz));
        reg_write(CFG_NONE, 16'($urandom));
        cfg_wr_en <= 1'b0;
        ox = nx; oy = ny; oz = nz;
    endtask

    // present one sample, with an optional leading gap, and hold until accepted
    task automatic send_sample(int x, int y, int z);
        int pct;
        pct = (mode == MODE_SRC) ? 63 : (mode == MODE_BOTH) ? 20 : 0;
        if ($urandom_range(99) < pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {16'(z), 16'(y), 16'(x)};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // wait for every result, then let any group still in flight settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    // sample near the offset most of the time, so angles sweep the circle
    function automatic int pick_axis(int off);
        int v;
        case ($urandom_range(9))
            0, 1:    v = int'($signed(16'($urandom)));
            2:       v = off;
            default: v = off + $urandom_range(4000) - 2000;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    initial begin
        logic [6:0] grp;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: axis cases and field extremes, one sample per group
        set_regs(7'd1, 0, 0, 0);
        send_sample(0, 0, 0);
        send_sample(0, 0, 5);
        send_sample(0, 0, -5);
        send_sample(5, 0, 0);
        send_sample(-5, 0, 0);
        send_sample(0, 5, 0);
        send_sample(0, -5, 0);
        send_sample(3, 4, -7);
        send_sample(-3, -4, 7);
        send_sample(32767, 32767, 32767);
        send_sample(-32768, -32768, -32768);
        send_sample(-32768, 32767, 0);
        send_sample(1, -1, 1);
        drain();
        // largest deviations both ways; group size zero counts as one
        set_regs(7'd0, -32768, -32768, 32767);
        send_sample(32767, 32767, -32768);
        send_sample(-32768, 32767, 32767);
        send_sample(32767, -32768, -32768);
        drain();
        set_regs(7'd127, 32767, -32768, 0);
        for (int i = 0; i < 64; i++) send_sample(-32768, 32767, 32767);
        drain();
        // shrink the group while it is partly filled: the next sample closes it
        set_regs(7'd64, 100, -100, 0);
        for (int i = 0; i < 5; i++) send_sample(-32768, 32767, 1000);
        drain();
        set_regs(7'd2, 100, -100, 0);
        send_sample(0, 0, -3);
        drain();

        // random phases cycling through the traffic modes
        for (int p = 0; p < 8; p++) begin
            case (p)
                2:       grp = 7'd64;
                3:       grp = 7'd127;
                4:       grp = 7'd1;
                default: grp = 7'($urandom_range(1, 16));
            endcase
            set_regs(grp, int'($signed(16'($urandom))) / ((p % 2) ? 1 : 64),
                     int'($signed(16'($urandom))) / ((p % 2) ? 1 : 64),
                     int'($signed(16'($urandom))) / ((p % 2) ? 1 : 64));
            mode = p % 4;
            // small groups and a long receiver hold-off fill the block up
            if (p == 4) holdoff_req++;
            for (int i = 0; i < 215; i++)
                send_sample(pick_axis(ox), pick_axis(oy), pick_axis(oz));
            drain();
        end

        if (errors == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end

endmodule

// File: accel_tilt_angle_averager.f
hdl/acctilt_pkg.sv
hdl/acctilt_fifo.sv
hdl/acctilt_front.sv
hdl/acctilt_back.sv
hdl/accel_tilt_angle_averager.sv
sim/tilt_checker.sv
sim/tb.sv
